/* rtl/pprp_pkg.sv */
`default_nettype none

package pprp_pkg;

  localparam int NORM_W     = 16;
  localparam int PIX_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;

  // lens codes
  localparam logic [1:0] MODE_UNKNOWN   = 2'd0;
  localparam logic [1:0] MODE_RECT      = 2'd1;
  localparam logic [1:0] MODE_EQUIDIST  = 2'd2;
  localparam logic [1:0] MODE_EQUISOLID = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAULT   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RSVD    = 2'd3;

  typedef enum logic [1:0] {
    KIND_PROJ,
    KIND_ZERO,
    KIND_DEGEN,
    KIND_UNKNOWN
  } kind_t;

  // ray direction plus how the item is finished
  typedef struct packed {
    kind_t              kind;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
  } ray_t;

  // one axis of the shared divider
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [31:0] rem;
    logic [33:0] q;
  } div_t;

  typedef struct packed {
    logic              sat;
    logic signed [15:0] val;
  } pix_t;

endpackage

`default_nettype wire

/* rtl/pprp_ifs.sv */
`default_nettype none

interface pprp_in_if import pprp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] norm_a_x;
  logic signed [NORM_W-1:0] norm_a_y;
  logic signed [NORM_W-1:0] norm_a_z;
  logic signed [NORM_W-1:0] norm_b_x;
  logic signed [NORM_W-1:0] norm_b_y;
  logic signed [NORM_W-1:0] norm_b_z;

  modport source (output valid, norm_a_x, norm_a_y, norm_a_z, norm_b_x, norm_b_y, norm_b_z,
                  input ready);
  modport sink (input valid, norm_a_x, norm_a_y, norm_a_z, norm_b_x, norm_b_y, norm_b_z,
                output ready);
endinterface

interface pprp_out_if import pprp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_col;
  logic signed [PIX_W-1:0] pixel_row;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, pixel_col, pixel_row, status, input ready);
  modport sink (input valid, pixel_col, pixel_row, status, output ready);
endinterface

interface pprp_cfg_if import pprp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/plane_pair_ray_to_pixel_unit.sv */
`default_nettype none
// Plane pair to pixel projector. Each input transfer carries two plane normals; the block
// takes their cross product as the viewing ray, flips it forward, projects it through the
// configured lens (pinhole, or the equidistant fisheye mapping for both fisheye codes) and returns
// the rounded, saturated pixel column and row with a status. It is a single fixed pipeline: one
// transfer is accepted every cycle while the result side is not stalled; its depth comes mostly
// from the 32 square-root stages, the CORDIC_STEPS angle stages and the 34 quotient-bit divider
// stages. A stall on the result side freezes the whole pipeline, so nothing is dropped.
// Configuration writes are always accepted; change registers only while no item is in flight.
module plane_pair_ray_to_pixel_unit import pprp_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pprp_cfg_if.sink    cfg_ch,
  pprp_in_if.sink     in_ch,
  pprp_out_if.source  out_ch
);

  localparam int SQ_STEPS = 32;  // one root bit per stage
  localparam int QB       = 34;  // quotient bits kept; larger points saturate anyway
  localparam int CW       = 36;  // CORDIC x/y width
  localparam int ZW       = 33;  // CORDIC angle width, Q2.30

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h3243F6A8;
      1: t = 32'h1DAC6705;
      2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;
      4: t = 32'h03FEAB76;
      5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;
      7: t = 32'h007FFF55;
      8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD;
      default: t = (i <= 30) ? 32'((64'd1 << (30 - i)) - 64'd1) : 32'd0;
    endcase
    return t;
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    return v[32] ? 32'(-v) : 32'(v);
  endfunction

  // (size-1)/2 - p, rounded half away from zero, saturated to 16 bits
  function automatic pix_t pixel_of(input logic [12:0] size, input logic signed [36:0] p);
    logic [27:0]        half;
    logic signed [38:0] v;
    logic [38:0]        mag;
    logic [22:0]        rm;
    pix_t               res;
    half = (size == 13'd0) ? 28'd0 : {size - 13'd1, 15'd0};
    v    = $signed({11'd0, half}) - 39'(p);
    mag  = v[38] ? 39'(-v) : 39'(v);
    rm   = 23'((mag + 39'd32768) >> 16);
    res.sat = 1'b0;
    if (!v[38]) begin
      if (rm > 23'd32767) begin
        res.sat = 1'b1;
        res.val = 16'sh7FFF;
      end else begin
        res.val = rm[15:0];
      end
    end else begin
      if (rm > 23'd32768) begin
        res.sat = 1'b1;
        res.val = 16'sh8000;
      end else begin
        res.val = 16'(17'd0 - {1'b0, rm[15:0]});
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [15:0]        focal_r;
  logic signed [15:0] centre_x_r;
  logic signed [15:0] centre_y_r;
  logic [1:0]         mode_r;
  logic [12:0]        width_r;
  logic [12:0]        height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r    <= '0;
      centre_x_r <= '0;
      centre_y_r <= '0;
      mode_r     <= MODE_UNKNOWN;
      width_r    <= 13'd1;
      height_r   <= 13'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FOCAL:    focal_r    <= cfg_ch.data;
        REG_CENTRE_X: centre_x_r <= $signed(cfg_ch.data);
        REG_CENTRE_Y: centre_y_r <= $signed(cfg_ch.data);
        REG_MODE:     mode_r     <= cfg_ch.data[1:0];
        REG_WIDTH:    width_r    <= cfg_ch.data[12:0];
        REG_HEIGHT:   height_r   <= cfg_ch.data[12:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together; the output register is the last stage.
  logic adv;
  logic out_v_r;
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------------------------------------------------------- S1: partial products
  logic signed [31:0] pr_r   [6];
  logic signed [31:0] pr_nxt [6];
  logic               v1_r;

  always_comb begin
    pr_nxt[0] = in_ch.norm_a_y * in_ch.norm_b_z;
    pr_nxt[1] = in_ch.norm_a_z * in_ch.norm_b_y;
    pr_nxt[2] = in_ch.norm_a_z * in_ch.norm_b_x;
    pr_nxt[3] = in_ch.norm_a_x * in_ch.norm_b_z;
    pr_nxt[4] = in_ch.norm_a_x * in_ch.norm_b_y;
    pr_nxt[5] = in_ch.norm_a_y * in_ch.norm_b_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) pr_r <= pr_nxt;
  end

  // ---------------------------------------------------------------- S2: cross product, flip
  ray_t ray2_r, ray2_nxt;
  logic v2_r;

  always_comb begin
    logic signed [32:0] dx, dy, dz;
    logic               flip;
    dx   = 33'(pr_r[0]) - 33'(pr_r[1]);
    dy   = 33'(pr_r[2]) - 33'(pr_r[3]);
    dz   = 33'(pr_r[4]) - 33'(pr_r[5]);
    flip = (dx != 33'sd0) ? dx[32] : dz[32];
    ray2_nxt.dx = flip ? -dx : dx;
    ray2_nxt.dy = flip ? -dy : dy;
    ray2_nxt.dz = flip ? -dz : dz;
    if (mode_r == MODE_UNKNOWN) begin
      ray2_nxt.kind = KIND_UNKNOWN;
    end else if (dx == 33'sd0 && dz == 33'sd0) begin
      ray2_nxt.kind = KIND_DEGEN;
    end else if (mode_r == MODE_RECT) begin
      ray2_nxt.kind = (dx == 33'sd0) ? KIND_DEGEN : KIND_PROJ;
    end else begin
      ray2_nxt.kind = (dy == 33'sd0 && dz == 33'sd0) ? KIND_ZERO : KIND_PROJ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) ray2_r <= ray2_nxt;
  end

  // ---------------------------------------------------------------- S3: largest magnitude
  ray_t        ray3_r;
  logic [31:0] m3_r, m3_nxt;
  logic        v3_r;

  always_comb begin
    logic [31:0] ax, ay, az, mxy;
    ax     = mag33(ray2_r.dx);
    ay     = mag33(ray2_r.dy);
    az     = mag33(ray2_r.dz);
    mxy    = (ay > ax) ? ay : ax;
    m3_nxt = (az > mxy) ? az : mxy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ray3_r <= ray2_r;
      m3_r   <= m3_nxt;
    end
  end

  // ---------------------------------------------------------------- S4: shift count
  // doublings until the largest magnitude reaches 2^30
  ray_t       ray4_r;
  logic [4:0] sh4_r, sh4_nxt;
  logic       v4_r;

  always_comb begin
    sh4_nxt = 5'd0;
    for (int i = 0; i < 30; i++) begin
      if (m3_r[i]) sh4_nxt = 5'(30 - i);
    end
    if (m3_r[31] || m3_r[30]) sh4_nxt = 5'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ray4_r <= ray3_r;
      sh4_r  <= sh4_nxt;
    end
  end

  // ---------------------------------------------------------------- S5: normalize
  ray_t ray5_r, ray5_nxt;
  logic v5_r;

  always_comb begin
    ray5_nxt    = ray4_r;
    ray5_nxt.dx = ray4_r.dx <<< sh4_r;
    ray5_nxt.dy = ray4_r.dy <<< sh4_r;
    ray5_nxt.dz = ray4_r.dz <<< sh4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (adv) ray5_r <= ray5_nxt;
  end

  // ---------------------------------------------------------------- S6: squares
  ray_t        ray6_r;
  logic [63:0] sqy_r, sqz_r, sqy_nxt, sqz_nxt;
  logic        v6_r;

  always_comb begin
    logic signed [65:0] ty, tz;
    ty      = ray5_r.dy * ray5_r.dy;
    tz      = ray5_r.dz * ray5_r.dz;
    sqy_nxt = ty[63:0];
    sqz_nxt = tz[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ray6_r <= ray5_r;
      sqy_r  <= sqy_nxt;
      sqz_r  <= sqz_nxt;
    end
  end

  // ---------------------------------------------------------------- integer square root
  logic [63:0] iq_n_r   [0:SQ_STEPS];
  logic [63:0] iq_res_r [0:SQ_STEPS];
  ray_t        iq_ray_r [0:SQ_STEPS];
  logic        iq_v_r   [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) iq_v_r[0] <= 1'b0;
    else if (adv) iq_v_r[0] <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      iq_n_r[0]   <= sqy_r + sqz_r;
      iq_res_r[0] <= '0;
      iq_ray_r[0] <= ray6_r;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [64:0] BIT = 65'(1) << (62 - 2 * k);
    logic [64:0] sum;
    logic        take;
    logic [63:0] n_nxt, res_nxt;

    always_comb begin
      sum     = {1'b0, iq_res_r[k]} + BIT;
      take    = ({1'b0, iq_n_r[k]} >= sum);
      n_nxt   = take ? (iq_n_r[k] - sum[63:0]) : iq_n_r[k];
      res_nxt = take ? ((iq_res_r[k] >> 1) + BIT[63:0]) : (iq_res_r[k] >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) iq_v_r[k+1] <= 1'b0;
      else if (adv) iq_v_r[k+1] <= iq_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        iq_n_r[k+1]   <= n_nxt;
        iq_res_r[k+1] <= res_nxt;
        iq_ray_r[k+1] <= iq_ray_r[k];
      end
    end
  end

  // ---------------------------------------------------------------- CORDIC vectoring
  // angle of (dx, rho) in Q2.30 radians
  logic signed [CW-1:0] c_x_r   [0:CORDIC_STEPS];
  logic signed [CW-1:0] c_y_r   [0:CORDIC_STEPS];
  logic signed [ZW-1:0] c_z_r   [0:CORDIC_STEPS];
  logic [31:0]          c_rho_r [0:CORDIC_STEPS];
  ray_t                 c_ray_r [0:CORDIC_STEPS];
  logic                 c_v_r   [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r[0] <= 1'b0;
    else if (adv) c_v_r[0] <= iq_v_r[SQ_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_x_r[0]   <= CW'(iq_ray_r[SQ_STEPS].dx);
      c_y_r[0]   <= $signed({4'd0, iq_res_r[SQ_STEPS][31:0]});
      c_z_r[0]   <= '0;
      c_rho_r[0] <= iq_res_r[SQ_STEPS][31:0];
      c_ray_r[0] <= iq_ray_r[SQ_STEPS];
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    localparam logic signed [ZW-1:0] ANG = $signed(ZW'(atan_q30(j)));
    logic signed [CW-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      xs = c_x_r[j] >>> j;
      ys = c_y_r[j] >>> j;
      if (!c_y_r[j][CW-1]) begin
        x_nxt = c_x_r[j] + ys;
        y_nxt = c_y_r[j] - xs;
        z_nxt = c_z_r[j] + ANG;
      end else begin
        x_nxt = c_x_r[j] - ys;
        y_nxt = c_y_r[j] + xs;
        z_nxt = c_z_r[j] - ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) c_v_r[j+1] <= 1'b0;
      else if (adv) c_v_r[j+1] <= c_v_r[j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c_x_r[j+1]   <= x_nxt;
        c_y_r[j+1]   <= y_nxt;
        c_z_r[j+1]   <= z_nxt;
        c_rho_r[j+1] <= c_rho_r[j];
        c_ray_r[j+1] <= c_ray_r[j];
      end
    end
  end

  // ---------------------------------------------------------------- R: fisheye radius
  logic [29:0] r_r, r_nxt;
  logic [31:0] r_rho_r;
  ray_t        r_ray_r;
  logic        r_v_r;

  always_comb begin
    logic [31:0] theta;
    logic [47:0] prod;
    theta = c_z_r[CORDIC_STEPS][ZW-1] ? 32'd0 : c_z_r[CORDIC_STEPS][31:0];
    prod  = focal_r * theta;
    r_nxt = prod[47:18];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) r_v_r <= 1'b0;
    else if (adv) r_v_r <= c_v_r[CORDIC_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r_r     <= r_nxt;
      r_rho_r <= c_rho_r[CORDIC_STEPS];
      r_ray_r <= c_ray_r[CORDIC_STEPS];
    end
  end

  // ---------------------------------------------------------------- M: dividend and divisor
  // pinhole: focal*d*4096 / dx, fisheye: r*d / rho
  logic signed [63:0] m_num_r [2];
  logic signed [63:0] m_num_nxt [2];
  logic [31:0]        m_den_r, m_den_nxt;
  ray_t               m_ray_r;
  logic               m_v_r;

  always_comb begin
    logic               fish;
    logic [30:0]        a;
    logic signed [64:0] py, pz;
    fish         = (mode_r != MODE_RECT);
    a            = fish ? {1'b0, r_r} : {15'd0, focal_r};
    py           = $signed({1'b0, a}) * r_ray_r.dy;
    pz           = $signed({1'b0, a}) * r_ray_r.dz;
    m_num_nxt[0] = fish ? py[63:0] : {py[51:0], 12'd0};
    m_num_nxt[1] = fish ? pz[63:0] : {pz[51:0], 12'd0};
    if (fish) m_den_nxt = (r_rho_r == 32'd0) ? 32'd1 : r_rho_r;
    else      m_den_nxt = r_ray_r.dx[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else if (adv) m_v_r <= r_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_num_r <= m_num_nxt;
      m_den_r <= m_den_nxt;
      m_ray_r <= r_ray_r;
    end
  end

  // ---------------------------------------------------------------- divider, two axes
  div_t        dv_r     [0:QB][2];
  logic [31:0] dv_den_r [0:QB];
  ray_t        dv_ray_r [0:QB];
  logic        dv_v_r   [0:QB];

  for (genvar a = 0; a < 2; a++) begin : g_div_in
    div_t d_nxt;
    always_comb begin
      logic [63:0] mag;
      mag       = m_num_r[a][63] ? 64'(-m_num_r[a]) : 64'(m_num_r[a]);
      d_nxt.neg = m_num_r[a][63];
      d_nxt.ovf = ({3'd0, mag[62:34]} >= m_den_r);
      d_nxt.rem = {3'd0, mag[62:34]};
      d_nxt.q   = mag[33:0];
    end
    always_ff @(posedge clk) begin
      if (adv) dv_r[0][a] <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= m_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_den_r[0] <= m_den_r;
      dv_ray_r[0] <= m_ray_r;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    for (genvar a = 0; a < 2; a++) begin : g_axis
      div_t d_nxt;
      always_comb begin
        logic [32:0] t;
        logic        ge;
        t         = {dv_r[k][a].rem, dv_r[k][a].q[QB-1]};
        ge        = (t >= {1'b0, dv_den_r[k]});
        d_nxt     = dv_r[k][a];
        d_nxt.rem = ge ? 32'(t - {1'b0, dv_den_r[k]}) : t[31:0];
        d_nxt.q   = {dv_r[k][a].q[QB-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (adv) dv_r[k+1][a] <= d_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else if (adv) dv_v_r[k+1] <= dv_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den_r[k+1] <= dv_den_r[k];
        dv_ray_r[k+1] <= dv_ray_r[k];
      end
    end
  end

  // ---------------------------------------------------------------- P: screen point
  logic signed [36:0] p_r   [2];
  logic signed [36:0] p_nxt [2];
  kind_t              p_kind_r;
  logic               p_v_r;

  always_comb begin
    logic               add_c;
    logic [34:0]        qm;
    logic signed [35:0] sq;
    logic signed [36:0] cen;
    add_c = (mode_r != MODE_RECT) && (dv_ray_r[QB].kind == KIND_PROJ);
    for (int a = 0; a < 2; a++) begin
      qm  = dv_r[QB][a].ovf ? (35'd1 << QB) : {1'b0, dv_r[QB][a].q};
      sq  = dv_r[QB][a].neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      cen = (a == 0) ? (37'(centre_x_r) <<< 12) : (37'(centre_y_r) <<< 12);
      if (dv_ray_r[QB].kind != KIND_PROJ) p_nxt[a] = '0;
      else p_nxt[a] = 37'(sq) + (add_c ? cen : 37'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else if (adv) p_v_r <= dv_v_r[QB];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r      <= p_nxt;
      p_kind_r <= dv_ray_r[QB].kind;
    end
  end

  // ---------------------------------------------------------------- output register
  logic signed [15:0]  out_col_r, out_row_r, out_col_nxt, out_row_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;

  always_comb begin
    pix_t pc, pr;
    pc = pixel_of(width_r, p_r[0]);
    pr = pixel_of(height_r, p_r[1]);
    out_col_nxt = pc.val;
    out_row_nxt = pr.val;
    case (p_kind_r)
      KIND_DEGEN: begin
        out_col_nxt = '0;
        out_row_nxt = '0;
        out_st_nxt  = STATUS_FAULT;
      end
      KIND_UNKNOWN: out_st_nxt = (pc.sat || pr.sat) ? STATUS_FAULT : STATUS_UNKNOWN;
      default:      out_st_nxt = (pc.sat || pr.sat) ? STATUS_FAULT : STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= p_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.pixel_col = out_col_r;
  assign out_ch.pixel_row = out_row_r;
  assign out_ch.status    = out_st_r;

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_st_r != STATUS_RSVD)
    else $error("reserved status code on result");

  a_unknown_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_st_r == STATUS_UNKNOWN) |-> mode_r == MODE_UNKNOWN)
    else $error("unknown-projection status with a known lens");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(out_col_r) && $stable(out_row_r)))
    else $error("result changed while stalled");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted item missing from first stage");
`endif

endmodule

`default_nettype wire
